// ===== rtl/core/link_presence_echo_handshake_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the link presence/echo handshake
// Shared property wrappers, clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LINK_PRESENCE_ECHO_HANDSHAKE_DEFINES_SVH
`define LINK_PRESENCE_ECHO_HANDSHAKE_DEFINES_SVH

// same-cycle implication
`define LPEH_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LPEH_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/lpeh_pkg.sv =====
// ----------------------------------------------------------------------------
// lpeh_pkg
// Types, codes and helpers for the link presence/echo handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpeh_pkg;

	localparam int unsigned MAX_CHARS = 8;

	// request codes
	typedef enum logic [1:0] {
		REQ_START   = 2'd0,
		REQ_TICK    = 2'd1,
		REQ_RX_BYTE = 2'd2,
		REQ_TX_DONE = 2'd3
	} req_t;

	// failure reasons
	localparam logic [1:0] FAIL_NONE        = 2'd0;
	localparam logic [1:0] FAIL_NO_PRESENCE = 2'd1;
	localparam logic [1:0] FAIL_HANDSHAKE   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_TIMEOUT   = 2'd0;
	localparam logic [1:0] CFG_THRESHOLD = 2'd1;
	localparam logic [1:0] CFG_CHARS     = 2'd2;
	localparam logic [1:0] CFG_LENGTH    = 2'd3;

	// configuration reset values
	localparam logic [15:0] TIMEOUT_RST   = 16'd2000;
	localparam logic [7:0]  THRESHOLD_RST = 8'd10;
	localparam logic [63:0] CHARS_RST     = 64'd0;
	localparam logic [3:0]  LENGTH_RST    = 4'd8;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'b0001,
		PH_PRESENCE = 4'b0010,
		PH_TX_WAIT  = 4'b0100,
		PH_RX_WAIT  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [7:0]  presence_threshold;
		logic [63:0] control_chars;
		logic [3:0]  control_length;
	} cfg_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       cts_high;
		logic [7:0] rx_byte;
		logic       tx_ok;
	} item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       finished;
		logic       success;
		logic [1:0] fail_reason;
	} res_t;

	// character count in use, clamped to the character field
	function automatic logic [3:0] used_length(input logic [3:0] len);
		used_length = (len > 4'(MAX_CHARS)) ? 4'(MAX_CHARS) : len;
	endfunction

	// byte at a position, first character in the low byte
	function automatic logic [7:0] char_at(input logic [63:0] chars, input logic [3:0] pos);
		char_at = chars[pos[2:0]*8 +: 8];
	endfunction

endpackage

// ===== rtl/core/lpeh_if.sv =====
// ----------------------------------------------------------------------------
// lpeh channel interfaces
// Request, result and configuration-write channels with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lpeh_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic       cts_high;
	logic [7:0] rx_byte;
	logic       tx_ok;

	modport source (output valid, req_type, cts_high, rx_byte, tx_ok, input ready);
	modport sink   (input valid, req_type, cts_high, rx_byte, tx_ok, output ready);
endinterface

interface lpeh_res_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       finished;
	logic       success;
	logic [1:0] fail_reason;

	modport source (output valid, tx_valid, tx_byte, finished, success, fail_reason,
		input ready);
	modport sink   (input valid, tx_valid, tx_byte, finished, success, fail_reason,
		output ready);
endinterface

interface lpeh_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  reg_index;
	logic [63:0] wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/core/lpeh_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lpeh_cfg_regs
// Configuration register file; takes one write transfer per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpeh_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	lpeh_cfg_if.sink         cfg,
	output lpeh_pkg::cfg_t   regs
);

	lpeh_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.timeout_ticks      <= lpeh_pkg::TIMEOUT_RST;
			regs_q.presence_threshold <= lpeh_pkg::THRESHOLD_RST;
			regs_q.control_chars      <= lpeh_pkg::CHARS_RST;
			regs_q.control_length     <= lpeh_pkg::LENGTH_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.reg_index)
				lpeh_pkg::CFG_TIMEOUT:   regs_q.timeout_ticks      <= cfg.wdata[15:0];
				lpeh_pkg::CFG_THRESHOLD: regs_q.presence_threshold <= cfg.wdata[7:0];
				lpeh_pkg::CFG_CHARS:     regs_q.control_chars      <= cfg.wdata;
				lpeh_pkg::CFG_LENGTH:    regs_q.control_length     <= cfg.wdata[3:0];
			endcase
		end
	end

endmodule

// ===== rtl/core/link_presence_echo_handshake.sv =====
// ----------------------------------------------------------------------------
// link_presence_echo_handshake
// Serial link bring-up: CTS presence sensing, then send-and-echo handshake.
// ----------------------------------------------------------------------------
//  port   dir    kind         contents
//  req    sink   valid/ready  req_type, cts_high, rx_byte, tx_ok
//  res    source valid/ready  tx_valid, tx_byte, finished, success, fail_reason
//  cfg    sink   valid/ready  reg_index, wdata (always ready)
//
//  One item per cycle sustained while res is not stalled; each item gives exactly one result.
//  Items are registered in the input register (_s1), then in the result register.
//  All state updates happen in the logic between those registers.
//  A stalled result holds the input stage; req.ready drops only when both are full.
//  Reset returns the phase to idle, clears the counters and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module link_presence_echo_handshake (
	input  logic       clk,
	input  logic       arst_n,
	lpeh_req_if.sink   req,
	lpeh_res_if.source res,
	lpeh_cfg_if.sink   cfg
);

	lpeh_pkg::cfg_t   cfg_regs;

	logic             valid_s1;
	lpeh_pkg::item_t  item_s1;
	logic             adv;

	lpeh_pkg::phase_t phase_q, phase_nx;
	logic [15:0]      elapsed_q, elapsed_nx, elapsed_inc;
	logic [7:0]       conf_q, conf_nx, conf_tick;
	logic [3:0]       pos_q, pos_nx, pos_inc, len_used;
	logic             timed_out;
	lpeh_pkg::req_t   req_code;

	logic             res_valid_q;
	lpeh_pkg::res_t   res_q, res_nx;

	lpeh_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_regs)
	);

	// handshake control
	assign adv       = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || adv;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.req_type <= req.req_type;
			item_s1.cts_high <= req.cts_high;
			item_s1.rx_byte  <= req.rx_byte;
			item_s1.tx_ok    <= req.tx_ok;
		end
	end

	// shared arithmetic
	assign req_code    = lpeh_pkg::req_t'(item_s1.req_type);
	assign len_used    = lpeh_pkg::used_length(cfg_regs.control_length);
	assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
	assign timed_out   = elapsed_inc >= cfg_regs.timeout_ticks;
	assign pos_inc     = pos_q + 4'd1;
	assign conf_tick   = item_s1.cts_high ? ((conf_q == 8'd0) ? conf_q : conf_q - 8'd1)
	                                      : ((conf_q == 8'hFF) ? conf_q : conf_q + 8'd1);

	// next state and result
	always_comb begin
		phase_nx   = phase_q;
		elapsed_nx = elapsed_q;
		conf_nx    = conf_q;
		pos_nx     = pos_q;
		res_nx     = '0;
		if (req_code == lpeh_pkg::REQ_START) begin
			phase_nx   = lpeh_pkg::PH_PRESENCE;
			elapsed_nx = '0;
			conf_nx    = '0;
			pos_nx     = '0;
		end else begin
			unique case (phase_q)
				lpeh_pkg::PH_PRESENCE: begin
					if (req_code == lpeh_pkg::REQ_TICK) begin
						conf_nx = conf_tick;
						if (conf_tick >= cfg_regs.presence_threshold) begin
							pos_nx = '0;
							if (len_used == 4'd0) begin
								phase_nx        = lpeh_pkg::PH_IDLE;
								res_nx.finished = 1'b1;
								res_nx.success  = 1'b1;
							end else begin
								phase_nx        = lpeh_pkg::PH_TX_WAIT;
								res_nx.tx_valid = 1'b1;
								res_nx.tx_byte  =
									lpeh_pkg::char_at(cfg_regs.control_chars, 4'd0);
							end
						end else begin
							elapsed_nx = elapsed_inc;
							if (timed_out) begin
								phase_nx           = lpeh_pkg::PH_IDLE;
								res_nx.finished    = 1'b1;
								res_nx.fail_reason = lpeh_pkg::FAIL_NO_PRESENCE;
							end
						end
					end
				end
				lpeh_pkg::PH_TX_WAIT: begin
					if (req_code == lpeh_pkg::REQ_TICK) begin
						elapsed_nx = elapsed_inc;
						if (timed_out) begin
							phase_nx           = lpeh_pkg::PH_IDLE;
							res_nx.finished    = 1'b1;
							res_nx.fail_reason = lpeh_pkg::FAIL_HANDSHAKE;
						end
					end else if (req_code == lpeh_pkg::REQ_TX_DONE) begin
						if (item_s1.tx_ok) begin
							phase_nx = lpeh_pkg::PH_RX_WAIT;
						end else begin
							phase_nx           = lpeh_pkg::PH_IDLE;
							res_nx.finished    = 1'b1;
							res_nx.fail_reason = lpeh_pkg::FAIL_HANDSHAKE;
						end
					end
				end
				lpeh_pkg::PH_RX_WAIT: begin
					if (req_code == lpeh_pkg::REQ_TICK) begin
						elapsed_nx = elapsed_inc;
						if (timed_out) begin
							phase_nx           = lpeh_pkg::PH_IDLE;
							res_nx.finished    = 1'b1;
							res_nx.fail_reason = lpeh_pkg::FAIL_HANDSHAKE;
						end
					end else if (req_code == lpeh_pkg::REQ_RX_BYTE) begin
						// echo of the current character moves to the next one
						if (item_s1.rx_byte ==
						    lpeh_pkg::char_at(cfg_regs.control_chars, pos_q)) begin
							pos_nx = pos_inc;
							if (pos_inc >= len_used) begin
								phase_nx        = lpeh_pkg::PH_IDLE;
								res_nx.finished = 1'b1;
								res_nx.success  = 1'b1;
							end else begin
								phase_nx        = lpeh_pkg::PH_TX_WAIT;
								res_nx.tx_valid = 1'b1;
								res_nx.tx_byte  =
									lpeh_pkg::char_at(cfg_regs.control_chars, pos_inc);
							end
						end
					end
				end
				default: begin
					// idle: everything but a start is dropped
				end
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lpeh_pkg::PH_IDLE;
			elapsed_q <= '0;
			conf_q    <= '0;
			pos_q     <= '0;
		end else if (adv) begin
			phase_q   <= phase_nx;
			elapsed_q <= elapsed_nx;
			conf_q    <= conf_nx;
			pos_q     <= pos_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nx;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.tx_valid    = res_q.tx_valid;
	assign res.tx_byte     = res_q.tx_byte;
	assign res.finished    = res_q.finished;
	assign res.success     = res_q.success;
	assign res.fail_reason = res_q.fail_reason;

endmodule

// ===== rtl/core/lpeh_checker.sv =====
// ----------------------------------------------------------------------------
// lpeh_checker
// Port-level checks on the result channel of the link handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "link_presence_echo_handshake_defines.svh"

module lpeh_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       tx_valid,
	input logic [7:0] tx_byte,
	input logic       finished,
	input logic       success,
	input logic [1:0] fail_reason
);

	// success only on a finish, with no reason
	`LPEH_ASSERT_IMPL(a_success_clean, res_valid && success, finished && fail_reason == lpeh_pkg::FAIL_NONE, "success without clean finish")

	// a failed finish names a real reason
	`LPEH_ASSERT_IMPL(a_fail_reason, res_valid && finished && !success, fail_reason == lpeh_pkg::FAIL_NO_PRESENCE || fail_reason == lpeh_pkg::FAIL_HANDSHAKE, "failed finish without reason")

	// no outcome reported while the attempt is still running
	`LPEH_ASSERT_IMPL(a_running_quiet, res_valid && !finished, !success && fail_reason == lpeh_pkg::FAIL_NONE, "outcome flags while running")

	// a character request never ends the attempt; idle byte reads zero
	`LPEH_ASSERT_IMPL(a_tx_not_final, res_valid, tx_valid ? !finished : tx_byte == 8'd0, "transmit request inconsistent")

	// a stalled result holds
	`LPEH_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable({tx_valid, tx_byte, finished, success, fail_reason}), "stalled result changed")

endmodule

bind link_presence_echo_handshake lpeh_checker u_lpeh_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.tx_valid    (res.tx_valid),
	.tx_byte     (res.tx_byte),
	.finished    (res.finished),
	.success     (res.success),
	.fail_reason (res.fail_reason)
);
